### rtl/prefix_expansion_route_lookup_macros.svh
// assertion macros for the route lookup checker
`ifndef PREFIX_EXPANSION_ROUTE_LOOKUP_MACROS_SVH
`define PREFIX_EXPANSION_ROUTE_LOOKUP_MACROS_SVH

// consequent in the same cycle
`define PXR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pxr check failed");

// consequent in the next cycle
`define PXR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pxr check failed");

`endif

### rtl/pxr_pkg.sv
// shared constants for the prefix expansion route lookup
package pxr_pkg;

  localparam int ADDR_BITS       = 32;
  localparam int LEN_W           = 6;
  localparam int INDEX_BITS_DEF  = 16;
  localparam int EXACT_DEPTH_DEF = 64;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_DROP = 1'b1;

endpackage

### rtl/pxr_ram.sv
// single write port, single registered read port memory
module pxr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/prefix_expansion_route_lookup.sv
// route table top level: sequencer over the direct table and exact-match memory
//
//   channel   ports                       handshake
//   input     in_action .. in_expected_hop start high, busy low
//   result    out_found_hop, out_hop_matches, out_status   out_valid strobe
//
// after reset the direct table is cleared slot by slot, with busy high
// lookup: checks each exact entry held, then reads the direct table if no key matched
// short insert: writes one direct slot per cycle, 2**(INDEX_BITS-len) slots covered
// long insert: checks each entry held, then for each covered address scans the entries
// held before the insert, appending the address if absent, until the exact table fills
// all of it paced by the single read port of each memory; results cannot be stalled
module prefix_expansion_route_lookup #(
  parameter int INDEX_BITS  = pxr_pkg::INDEX_BITS_DEF,
  parameter int EXACT_DEPTH = pxr_pkg::EXACT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [pxr_pkg::ADDR_BITS-1:0] in_address,
  input  logic [pxr_pkg::LEN_W-1:0]     in_prefix_len,
  input  logic [pxr_pkg::ADDR_BITS-1:0] in_route_hop,
  input  logic [pxr_pkg::ADDR_BITS-1:0] in_expected_hop,
  output logic                          out_valid,
  output logic [pxr_pkg::ADDR_BITS-1:0] out_found_hop,
  output logic                          out_hop_matches,
  output logic                          out_status
);

  localparam int AB           = pxr_pkg::ADDR_BITS;
  localparam int LW           = pxr_pkg::LEN_W;
  localparam int DIRECT_DEPTH = 1 << INDEX_BITS;
  localparam int IDX_W        = (EXACT_DEPTH > 1) ? $clog2(EXACT_DEPTH) : 1;
  localparam int CNT_W        = $clog2(EXACT_DEPTH + 1);
  localparam int ENTRY_W      = 2 * AB;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(EXACT_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DFILL,
    ST_OV_RD, ST_OV_CK,
    ST_AP_NEXT, ST_AP_RD, ST_AP_CK,
    ST_LK_RD, ST_LK_CK, ST_LK_DIR, ST_LK_DCK
  } state_t;

  state_t                 state_r;
  logic [AB-1:0]          addr_r;
  logic [AB-1:0]          hop_r;
  logic [AB-1:0]          exp_r;
  logic [AB-1:0]          lowmask_r;
  logic [AB-1:0]          a_r;
  logic [INDEX_BITS-1:0]  slot_r;
  logic [INDEX_BITS-1:0]  slot_mask_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CNT_W-1:0]       base_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       hold_r;
  logic                   out_valid_r;
  logic [AB-1:0]          out_found_hop_r;
  logic                   out_hop_matches_r;
  logic                   out_status_r;

  logic [LW-1:0]          len_sat;
  logic [INDEX_BITS-1:0]  dmask;
  logic [AB-1:0]          emask;
  logic [ENTRY_W-1:0]     ex_rd_data;
  logic [AB-1:0]          ex_key;
  logic [AB-1:0]          ex_hop;
  logic                   ex_we;
  logic [IDX_W-1:0]       ex_waddr;
  logic [ENTRY_W-1:0]     ex_wdata;
  logic                   dr_we;
  logic [AB-1:0]          dr_wdata;
  logic [AB-1:0]          dr_rd_data;
  logic                   key_in_range;
  logic                   key_is_a;
  logic                   key_is_addr;
  logic                   idx_last;
  logic                   a_last;
  logic                   slot_last;
  logic                   ex_full;
  logic                   append_now;
  logic [AB-1:0]          hold_ext;
  logic                   drop_cur;
  logic                   drop_inc;

  // prefix length above the address width saturates
  assign len_sat = (in_prefix_len > LW'(AB)) ? LW'(AB) : in_prefix_len;
  assign dmask   = {INDEX_BITS{1'b1}} >> len_sat;
  assign emask   = {AB{1'b1}} >> len_sat;

  assign ex_key       = ex_rd_data[ENTRY_W-1:AB];
  assign ex_hop       = ex_rd_data[AB-1:0];
  assign key_in_range = ((ex_key ^ addr_r) & ~lowmask_r) == '0;
  assign key_is_a     = ex_key == a_r;
  assign key_is_addr  = ex_key == addr_r;
  assign idx_last     = (CNT_W'(idx_r) + CNT_W'(1)) == base_r;
  assign a_last       = (a_r & lowmask_r) == lowmask_r;
  assign slot_last    = (slot_r & slot_mask_r) == slot_mask_r;
  assign ex_full      = count_r == FULL;
  assign hold_ext     = AB'(hold_r);
  assign drop_cur     = hold_ext <= lowmask_r;
  assign drop_inc     = (hold_ext + AB'(1)) <= lowmask_r;

  assign append_now = ((state_r == ST_AP_NEXT) && !ex_full && (base_r == '0)) ||
                      ((state_r == ST_AP_CK) && !key_is_a && idx_last);

  assign ex_we    = append_now || ((state_r == ST_OV_CK) && key_in_range);
  assign ex_waddr = (state_r == ST_OV_CK) ? idx_r : count_r[IDX_W-1:0];
  assign ex_wdata = (state_r == ST_OV_CK) ? {ex_key, hop_r} : {a_r, hop_r};

  assign dr_we    = (state_r == ST_CLEAR) || (state_r == ST_DFILL);
  assign dr_wdata = (state_r == ST_DFILL) ? hop_r : '0;

  pxr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (EXACT_DEPTH),
    .AW    (IDX_W)
  ) u_exact (
    .clk     (clk),
    .wr_en   (ex_we),
    .wr_addr (ex_waddr),
    .wr_data (ex_wdata),
    .rd_addr (idx_r),
    .rd_data (ex_rd_data)
  );

  pxr_ram #(
    .WIDTH (AB),
    .DEPTH (DIRECT_DEPTH),
    .AW    (INDEX_BITS)
  ) u_direct (
    .clk     (clk),
    .wr_en   (dr_we),
    .wr_addr (slot_r),
    .wr_data (dr_wdata),
    .rd_addr (addr_r[AB-1 -: INDEX_BITS]),
    .rd_data (dr_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      slot_r      <= '0;
      slot_mask_r <= '1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (slot_last) begin
            state_r <= ST_IDLE;
          end else begin
            slot_r <= slot_r + INDEX_BITS'(1);
          end
        end
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            addr_r <= in_address;
            hop_r  <= in_route_hop;
            exp_r  <= in_expected_hop;
            idx_r  <= '0;
            hold_r <= '0;
            base_r <= count_r;
            if (in_action == pxr_pkg::ACT_LOOKUP) begin
              state_r <= (count_r == '0) ? ST_LK_DIR : ST_LK_RD;
            end else if (len_sat <= LW'(INDEX_BITS)) begin
              slot_mask_r <= dmask;
              slot_r      <= in_address[AB-1 -: INDEX_BITS] & ~dmask;
              state_r     <= ST_DFILL;
            end else begin
              lowmask_r <= emask;
              a_r       <= in_address & ~emask;
              state_r   <= (count_r == '0) ? ST_AP_NEXT : ST_OV_RD;
            end
          end
        end
        ST_DFILL: begin
          if (slot_last) begin
            out_valid_r       <= 1'b1;
            out_found_hop_r   <= '0;
            out_hop_matches_r <= 1'b0;
            out_status_r      <= pxr_pkg::STAT_OK;
            state_r           <= ST_IDLE;
          end else begin
            slot_r <= slot_r + INDEX_BITS'(1);
          end
        end
        ST_OV_RD: begin
          state_r <= ST_OV_CK;
        end
        ST_OV_CK: begin
          if (key_in_range) begin
            hold_r <= hold_r + CNT_W'(1);
          end
          if (idx_last) begin
            idx_r   <= '0;
            state_r <= ST_AP_NEXT;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_OV_RD;
          end
        end
        ST_AP_NEXT: begin
          idx_r <= '0;
          if (ex_full) begin
            out_valid_r       <= 1'b1;
            out_found_hop_r   <= '0;
            out_hop_matches_r <= 1'b0;
            out_status_r      <= drop_cur;
            state_r           <= ST_IDLE;
          end else if (base_r == '0) begin
            count_r <= count_r + CNT_W'(1);
            hold_r  <= hold_r + CNT_W'(1);
            if (a_last) begin
              out_valid_r       <= 1'b1;
              out_found_hop_r   <= '0;
              out_hop_matches_r <= 1'b0;
              out_status_r      <= drop_inc;
              state_r           <= ST_IDLE;
            end else begin
              a_r <= a_r + AB'(1);
            end
          end else begin
            state_r <= ST_AP_RD;
          end
        end
        ST_AP_RD: begin
          state_r <= ST_AP_CK;
        end
        ST_AP_CK: begin
          if (key_is_a || idx_last) begin
            if (!key_is_a) begin
              count_r <= count_r + CNT_W'(1);
              hold_r  <= hold_r + CNT_W'(1);
            end
            if (a_last) begin
              out_valid_r       <= 1'b1;
              out_found_hop_r   <= '0;
              out_hop_matches_r <= 1'b0;
              out_status_r      <= key_is_a ? drop_cur : drop_inc;
              state_r           <= ST_IDLE;
            end else begin
              a_r     <= a_r + AB'(1);
              state_r <= ST_AP_NEXT;
            end
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_AP_RD;
          end
        end
        ST_LK_RD: begin
          state_r <= ST_LK_CK;
        end
        ST_LK_CK: begin
          if (key_is_addr) begin
            out_valid_r       <= 1'b1;
            out_found_hop_r   <= ex_hop;
            out_hop_matches_r <= ex_hop == exp_r;
            out_status_r      <= pxr_pkg::STAT_OK;
            state_r           <= ST_IDLE;
          end else if (idx_last) begin
            state_r <= ST_LK_DIR;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_LK_RD;
          end
        end
        ST_LK_DIR: begin
          state_r <= ST_LK_DCK;
        end
        ST_LK_DCK: begin
          out_valid_r       <= 1'b1;
          out_found_hop_r   <= dr_rd_data;
          out_hop_matches_r <= dr_rd_data == exp_r;
          out_status_r      <= pxr_pkg::STAT_OK;
          state_r           <= ST_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_found_hop   = out_found_hop_r;
  assign out_hop_matches = out_hop_matches_r;
  assign out_status      = out_status_r;

endmodule

### rtl/pxr_checker.sv
// port-level checks for the route lookup, bound to the top level
`include "prefix_expansion_route_lookup_macros.svh"

module pxr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [pxr_pkg::ADDR_BITS-1:0] out_found_hop,
  input logic                          out_hop_matches,
  input logic                          out_status
);

  // a result frees the block in the same cycle
  `PXR_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy)

  // an accepted transaction always makes the block busy
  `PXR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // no result without a transaction
  `PXR_ASSERT_NEXT(a_no_spurious, clk, rst_n, !busy && !start, !out_valid)

  // a dropped insert reports no hop
  `PXR_ASSERT_SAME(a_drop_clean, clk, rst_n,
    out_valid && (out_status == pxr_pkg::STAT_DROP),
    (out_found_hop == '0) && !out_hop_matches)

endmodule

bind prefix_expansion_route_lookup pxr_checker u_pxr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_found_hop   (out_found_hop),
  .out_hop_matches (out_hop_matches),
  .out_status      (out_status)
);

### test/prefix_expansion_route_lookup_tb.sv
// testbench for the prefix expansion route lookup: directed table then random routes and lookups
module prefix_expansion_route_lookup_tb;

  localparam int   ADDR_BITS   = pxr_pkg::ADDR_BITS;
  localparam int   LEN_W       = pxr_pkg::LEN_W;
  localparam logic ACT_INSERT  = pxr_pkg::ACT_INSERT;
  localparam logic ACT_LOOKUP  = pxr_pkg::ACT_LOOKUP;
  localparam logic STAT_OK     = pxr_pkg::STAT_OK;
  localparam logic STAT_DROP   = pxr_pkg::STAT_DROP;

  localparam int INDEX_BITS  = pxr_pkg::INDEX_BITS_DEF;
  localparam int EXACT_DEPTH = pxr_pkg::EXACT_DEPTH_DEF;
  localparam int DIRECT_SIZE = 1 << INDEX_BITS;
  localparam int RANDOM_ITEMS = 1080;
  localparam int CALM_TAIL    = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic                 action;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_W-1:0]     prefix_len;
    logic [ADDR_BITS-1:0] route_hop;
    logic [ADDR_BITS-1:0] expected_hop;
  } route_cmd_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] found_hop;
    logic                 hop_matches;
    logic                 status;
  } hop_result_t;

  typedef struct packed {
    logic                 action;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_W-1:0]     prefix_len;
    logic [ADDR_BITS-1:0] route_hop;
    logic [ADDR_BITS-1:0] expected_hop;
    logic                 typed;
    logic [ADDR_BITS-1:0] found_hop;
    logic                 hop_matches;
    logic                 status;
  } route_row_t;

  localparam int DIRECTED_ROWS = 26;

  // typed rows: reset state, extremes, drop status; the rest go through the predictor
  route_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{ACT_LOOKUP, 32'h0000_0000, 6'd0,  32'h0, 32'h0, 1'b1, 32'h0, 1'b1, STAT_OK},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'h1234_5678, 6'd0,  32'h0A00_0001, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'hDEAD_BEEF, 6'd0,  32'h0, 32'h0A00_0001,
      1'b1, 32'h0A00_0001, 1'b1, STAT_OK},
    '{ACT_INSERT, 32'hFFFF_0000, 6'd16, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0, 32'hFFFF_FFFF,
      1'b1, 32'hFFFF_FFFF, 1'b1, STAT_OK},
    '{ACT_INSERT, 32'h8000_0000, 6'd1,  32'h0B00_0001, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'hFFFE_1234, 6'd0,  32'h0, 32'h0B00_0001, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'hC0A8_0000, 6'd8,  32'hC0A8_0001, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'hC0FF_EE00, 6'd0,  32'h0, 32'hC0A8_0001, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h1111_1111, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0, 32'h1111_1111,
      1'b1, 32'h1111_1111, 1'b1, STAT_OK},
    '{ACT_INSERT, 32'h0102_0304, 6'd63, 32'h2222_2222, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'h0102_0304, 6'd0,  32'h0, 32'h2222_2222, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'h0102_0304, 6'd32, 32'h3333_3333, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'hFFFF_FFFC, 6'd30, 32'h4444_4444, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'hFFFF_FFFD, 6'd0,  32'h0, 32'h4444_4444, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'h0102_0000, 6'd16, 32'h5555_5555, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'h0102_0304, 6'd0,  32'h0, 32'h5555_5555, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'h0102_0305, 6'd0,  32'h0, 32'h5555_5555, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'h0102_0305, 6'd33, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_INSERT, 32'h7FFF_8000, 6'd17, 32'h6666_6666, 32'h0, 1'b1, 32'h0, 1'b0, STAT_DROP},
    '{ACT_INSERT, 32'h0000_0001, 6'd32, 32'h7777_7777, 32'h0, 1'b1, 32'h0, 1'b0, STAT_DROP},
    '{ACT_INSERT, 32'h7FFF_8001, 6'd32, 32'h8888_8888, 32'h0, 1'b1, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'h7FFF_8001, 6'd0,  32'h0, 32'h8888_8888, 1'b0, 32'h0, 1'b0, STAT_OK},
    '{ACT_LOOKUP, 32'h7FFF_8040, 6'd0,  32'h0, 32'h0, 1'b0, 32'h0, 1'b0, STAT_OK}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_action;
  logic [ADDR_BITS-1:0] in_address;
  logic [LEN_W-1:0]     in_prefix_len;
  logic [ADDR_BITS-1:0] in_route_hop;
  logic [ADDR_BITS-1:0] in_expected_hop;
  logic                 out_valid;
  logic [ADDR_BITS-1:0] out_found_hop;
  logic                 out_hop_matches;
  logic                 out_status;

  logic [ADDR_BITS-1:0] slot_hop  [0:DIRECT_SIZE-1];
  logic [ADDR_BITS-1:0] host_key  [0:EXACT_DEPTH-1];
  logic [ADDR_BITS-1:0] host_hop  [0:EXACT_DEPTH-1];
  logic                 host_used [0:EXACT_DEPTH-1];
  int                   host_fill;

  hop_result_t          pending_hops [$];
  logic [ADDR_BITS-1:0] seen_prefixes [$];

  int     mismatches;
  int     lookups_done;
  int     inserts_done;
  int     drops_seen;
  int     hits_seen;
  longint cycle_count;
  longint cycle_limit;

  prefix_expansion_route_lookup #(
    .INDEX_BITS (INDEX_BITS),
    .EXACT_DEPTH(EXACT_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_prefix_len  (in_prefix_len),
    .in_route_hop   (in_route_hop),
    .in_expected_hop(in_expected_hop),
    .out_valid      (out_valid),
    .out_found_hop  (out_found_hop),
    .out_hop_matches(out_hop_matches),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int effective_len(input logic [LEN_W-1:0] prefix_len);
    return (prefix_len > ADDR_BITS) ? ADDR_BITS : int'(prefix_len);
  endfunction

  function automatic int host_index(input logic [ADDR_BITS-1:0] key);
    for (int i = 0; i < EXACT_DEPTH; i++)
      if (host_used[i] && host_key[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [ADDR_BITS-1:0] peek_hop(input logic [ADDR_BITS-1:0] addr);
    int k;
    k = host_index(addr);
    if (k >= 0) return host_hop[k];
    return slot_hop[addr[ADDR_BITS-1 -: INDEX_BITS]];
  endfunction

  function automatic void fill_slots(input logic [ADDR_BITS-1:0] addr, input int len,
                                     input logic [ADDR_BITS-1:0] hop);
    logic [ADDR_BITS:0] top;
    logic [ADDR_BITS:0] lo;
    logic [ADDR_BITS:0] hi;
    int                 fill;
    top  = (len == 0) ? '0 : ({1'b0, addr} >> (ADDR_BITS - len));
    fill = INDEX_BITS - len;
    lo   = top << fill;
    hi   = (top + 1) << fill;
    for (logic [ADDR_BITS:0] s = lo; s < hi && s < DIRECT_SIZE; s++)
      slot_hop[s[INDEX_BITS-1:0]] = hop;
  endfunction

  function automatic logic place_host_routes(input logic [ADDR_BITS-1:0] addr, input int len,
                                             input logic [ADDR_BITS-1:0] hop);
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS:0]   lo;
    logic [ADDR_BITS:0]   hi;
    logic [ADDR_BITS:0]   span_size;
    logic [ADDR_BITS:0]   a;
    logic [ADDR_BITS:0]   held;
    int                   span;
    span      = ADDR_BITS - len;
    base      = (addr >> span) << span;
    lo        = {1'b0, base};
    span_size = {{ADDR_BITS{1'b0}}, 1'b1} << span;
    hi        = lo + span_size;
    for (int i = 0; i < EXACT_DEPTH; i++)
      if (host_used[i] && host_key[i] >= lo && host_key[i] < hi) host_hop[i] = hop;
    a = lo;
    while (a < hi && host_fill < EXACT_DEPTH) begin
      if (host_index(a[ADDR_BITS-1:0]) < 0) begin
        host_key[host_fill]  = a[ADDR_BITS-1:0];
        host_hop[host_fill]  = hop;
        host_used[host_fill] = 1'b1;
        host_fill++;
      end
      a++;
    end
    held = '0;
    for (int i = 0; i < EXACT_DEPTH; i++)
      if (host_used[i] && host_key[i] >= lo && host_key[i] < hi) held++;
    return (held < span_size) ? STAT_DROP : STAT_OK;
  endfunction

  function automatic hop_result_t route_outcome(input route_cmd_t cmd);
    hop_result_t res;
    int          len;
    res = '0;
    len = effective_len(cmd.prefix_len);
    if (cmd.action == ACT_LOOKUP) begin
      res.found_hop   = peek_hop(cmd.address);
      res.hop_matches = (res.found_hop == cmd.expected_hop);
      res.status      = STAT_OK;
    end else if (len <= INDEX_BITS) begin
      fill_slots(cmd.address, len, cmd.route_hop);
      res.status = STAT_OK;
    end else begin
      res.status = place_host_routes(cmd.address, len, cmd.route_hop);
    end
    return res;
  endfunction

  // worst-case cycles for one transaction, reckoned from the work steps of the block
  function automatic longint service_bound(input route_cmd_t cmd);
    int len;
    len = effective_len(cmd.prefix_len);
    if (cmd.action == ACT_LOOKUP) return longint'(2 * EXACT_DEPTH + 8);
    if (len <= INDEX_BITS) return (longint'(1) << (INDEX_BITS - len)) + longint'(8);
    return longint'(2 * EXACT_DEPTH) * ((longint'(1) << (ADDR_BITS - len)) + longint'(2))
           + longint'(8);
  endfunction

  task automatic issue_route_cmd(input route_cmd_t cmd, input logic typed,
                                 input hop_result_t want, input int gap);
    hop_result_t model;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_action       <= cmd.action;
    in_address      <= cmd.address;
    in_prefix_len   <= cmd.prefix_len;
    in_route_hop    <= cmd.route_hop;
    in_expected_hop <= cmd.expected_hop;
    cycle_limit += 4 * (service_bound(cmd) + 16);
    @(posedge clk);
    while (busy) @(posedge clk);
    model = route_outcome(cmd);
    pending_hops = {pending_hops, (typed ? want : model)};
    if (cmd.action == ACT_LOOKUP) begin
      lookups_done++;
      if (model.found_hop != '0) hits_seen++;
    end else begin
      inserts_done++;
      if (model.status == STAT_DROP) drops_seen++;
      seen_prefixes = {seen_prefixes, cmd.address};
      if (seen_prefixes.size() > 32) void'(seen_prefixes.pop_front());
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, pending_hops.size());
      $display("prefix_expansion_route_lookup_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    hop_result_t want;
    if (rst_n && out_valid) begin
      if (pending_hops.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: found_hop %h hop_matches %b status %b",
                   out_found_hop, out_hop_matches, out_status);
      end else begin
        want = pending_hops.pop_front();
        if (out_found_hop !== want.found_hop || out_hop_matches !== want.hop_matches ||
            out_status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: found_hop %h/%h hop_matches %b/%b status %b/%b (exp/act)",
                     want.found_hop, out_found_hop, want.hop_matches, out_hop_matches,
                     want.status, out_status);
        end
      end
    end
  end

  initial begin
    route_cmd_t           cmd;
    hop_result_t          want;
    route_row_t           row;
    logic [ADDR_BITS-1:0] addr;
    int                   gap;
    int                   pick;
    logic                 calm;

    mismatches   = 0;
    lookups_done = 0;
    inserts_done = 0;
    drops_seen   = 0;
    hits_seen    = 0;
    cycle_count  = 0;
    cycle_limit  = 8 * DIRECT_SIZE + 10000;
    host_fill    = 0;
    for (int s = 0; s < DIRECT_SIZE; s++) slot_hop[s] = '0;
    for (int i = 0; i < EXACT_DEPTH; i++) begin
      host_key[i]  = '0;
      host_hop[i]  = '0;
      host_used[i] = 1'b0;
    end

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_action       <= ACT_INSERT;
    in_address      <= '0;
    in_prefix_len   <= '0;
    in_route_hop    <= '0;
    in_expected_hop <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row  = directed_rows[r];
      cmd  = '{row.action, row.address, row.prefix_len, row.route_hop, row.expected_hop};
      want = '{row.found_hop, row.hop_matches, row.status};
      gap  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
      issue_route_cmd(cmd, row.typed, want, gap);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_TAIL) || ((n / 80) % 3 == 2);
      gap  = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 13);
      pick = $urandom_range(0, 99);
      cmd.route_hop    = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
      cmd.expected_hop = $urandom;
      cmd.prefix_len   = LEN_W'($urandom_range(0, 63));
      if (pick < 70) begin
        cmd.action = ACT_LOOKUP;
        pick = $urandom_range(0, 9);
        if (pick < 4 && host_fill > 0)
          addr = host_key[$urandom_range(0, host_fill - 1)];
        else if (pick < 7 && seen_prefixes.size() > 0)
          addr = seen_prefixes[$urandom_range(0, seen_prefixes.size() - 1)]
                 ^ ($urandom >> $urandom_range(0, 31));
        else if (pick == 7)
          addr = $urandom_range(0, 1) ? '1 : '0;
        else
          addr = $urandom;
        cmd.address = addr;
        if ($urandom_range(0, 1)) cmd.expected_hop = peek_hop(addr);
      end else begin
        cmd.action = ACT_INSERT;
        pick = $urandom_range(0, 99);
        if (pick < 3)
          cmd.prefix_len = LEN_W'($urandom_range(0, 9));
        else if (pick < 55)
          cmd.prefix_len = LEN_W'($urandom_range(10, INDEX_BITS));
        else if (pick < 60)
          cmd.prefix_len = 6'd28;
        else if (pick < 66)
          cmd.prefix_len = LEN_W'($urandom_range(ADDR_BITS + 1, 63));
        else
          cmd.prefix_len = LEN_W'($urandom_range(29, ADDR_BITS));
        if ($urandom_range(0, 9) < 4 && host_fill > 0)
          cmd.address = host_key[$urandom_range(0, host_fill - 1)]
                        ^ ($urandom >> $urandom_range(24, 31));
        else
          cmd.address = $urandom;
      end
      issue_route_cmd(cmd, 1'b0, '0, gap);
    end
    start <= 1'b0;

    while (pending_hops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d lookups (%0d hit a route) and %0d route inserts", lookups_done,
             hits_seen, inserts_done);
    $display("exact table held %0d of %0d entries, %0d inserts dropped addresses, %0d mismatches",
             host_fill, EXACT_DEPTH, drops_seen, mismatches);
    if (mismatches == 0 && pending_hops.size() == 0) begin
      $display("prefix_expansion_route_lookup_tb OK");
    end else begin
      $display("prefix_expansion_route_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule
